FILE: design/pba_pkg.sv
`timescale 1ns / 1ps
// types, codes and constants of the page bitmap allocator
// no dependencies

package pba_pkg;

    localparam int DEF_MAX_PAGES = 65536;
    localparam int DEF_WORD_BITS = 64;
    localparam int MANAGED_RESET = 65536;

    localparam int OP_W      = 3;
    localparam int ST_W      = 3;
    localparam int PIDX_W    = 16;
    localparam int CNT_W     = 17;
    localparam int PNUM_W    = 52;
    localparam int IDX_W     = 18;
    localparam int CFG_IDX_W = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC     = 3'd0,
        OP_FREE      = 3'd1,
        OP_LOCK      = 3'd2,
        OP_UNLOCK    = 3'd3,
        OP_RESERVE   = 3'd4,
        OP_UNRESERVE = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_RANGE = 3'd2,
        ST_SET   = 3'd3,
        ST_CLEAR = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MANAGED = 4'd0,
        CFG_BASE    = 4'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_RD,
        S_EVAL,
        S_WR,
        S_CNT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PIDX_W-1:0] page_index;
        logic [CNT_W-1:0]  page_count;
    } t_cmd;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [PIDX_W-1:0] page_index_out;
        logic [PNUM_W-1:0] page_number;
        logic [CNT_W-1:0]  free_pages;
        logic [CNT_W-1:0]  locked_pages;
        logic [CNT_W-1:0]  reserved_pages;
    } t_result;

endpackage

FILE: design/page_bitmap_allocator_unit.sv
`timescale 1ns / 1ps
// page bitmap allocator: occupancy bitmap in one synchronous ram, next-fit
// allocate, free and run lock/unlock/reserve/unreserve
// depends on pba_pkg
//
//  channel   | signals                                        | transfer
//  ----------+------------------------------------------------+-------------------------
//  command   | start, busy, i_cmd                             | start high, busy low
//  result    | o_result_valid, o_result                       | every cycle valid is high
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | valid and ready high
//
// each bitmap word visited goes through ram read, evaluate, write back and count update in turn
// allocate searches up to (WORD_COUNT+1) words
// op codes 6 and 7 and errors found before any read answer without a ram read
// after reset a clearing pass over all WORD_COUNT words (1024 by default) holds busy
// high; configuration writes are taken at any time, results cannot be stalled

module page_bitmap_allocator_unit #(
    parameter int MAX_PAGES = pba_pkg::DEF_MAX_PAGES,
    parameter int WORD_BITS = pba_pkg::DEF_WORD_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  pba_pkg::t_cmd                      i_cmd,
    output logic                               o_result_valid,
    output pba_pkg::t_result                   o_result,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pba_pkg::PNUM_W-1:0]         i_cfg_data
);
    import pba_pkg::*;

    localparam int BW         = $clog2(WORD_BITS);
    localparam int ROW        = 1 << BW;
    localparam int WORD_COUNT = (MAX_PAGES + ROW - 1) / ROW;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int WW         = IDX_W - BW;
    localparam int LIM_RESET  = (MANAGED_RESET < MAX_PAGES) ? MANAGED_RESET : MAX_PAGES;

    logic [ROW-1:0]    r_mem [WORD_COUNT];
    logic [ROW-1:0]    r_rdata;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr_addr;
    logic [CNT_W-1:0]  r_lim;
    logic [PNUM_W-1:0] r_base;
    logic [CNT_W-1:0]  r_cursor;
    logic [CNT_W-1:0]  r_locked;
    logic [CNT_W-1:0]  r_reserved;

    logic [OP_W-1:0]   r_op;
    logic [PIDX_W-1:0] r_first;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_end;
    logic              r_short;
    logic [WW-1:0]     r_w;
    logic [WW-1:0]     r_w0;
    logic [BW-1:0]     r_o0;
    logic              r_first_visit;
    logic              r_final;
    logic [BW:0]       r_lo;
    logic [BW:0]       r_hi;
    logic [ROW-1:0]    r_wdata;
    logic              r_hit;
    logic              r_last;
    logic [BW-1:0]     r_fpos;
    logic [BW:0]       r_pop;
    t_status           r_status;
    logic [PIDX_W-1:0] r_idx_out;
    logic [PNUM_W-1:0] r_pnum;

    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_waddr;
    logic [ROW-1:0]    mem_wdata;

    logic              is_alloc;
    logic              is_run;
    logic              set_bits;
    logic              invert;
    logic              to_reserved;

    logic [CNT_W-1:0]  c0;
    logic [CNT_W-1:0]  run_n;
    logic [IDX_W-1:0]  run_sum;
    logic              run_short;
    logic [IDX_W-1:0]  run_end;
    logic              first_out;
    logic              start_done;

    logic [WW-1:0]     end_w;
    logic [BW-1:0]     end_lo;
    logic [BW:0]       lo_val;
    logic [BW:0]       hi_val;

    logic [ROW-1:0]    mask;
    logic [ROW-1:0]    cand;
    logic [ROW-1:0]    lowest;
    logic [ROW-1:0]    chg;
    logic [ROW-1:0]    wnew;
    logic [BW-1:0]     fpos;
    logic              last_w;

    logic [CNT_W-1:0]  cnt_sel;
    logic [CNT_W:0]    cnt_up;
    logic [CNT_W-1:0]  cnt_new;
    logic [IDX_W-1:0]  hit_idx;
    logic [WW-1:0]     nxt_w;
    logic              cnt_done;

    logic [CNT_W:0]    used;
    logic [CNT_W-1:0]  free_cnt;

    // op decode
    always_comb begin
        is_alloc    = (r_op == OP_ALLOC);
        is_run      = !is_alloc && (r_op <= OP_UNRESERVE);
        set_bits    = is_alloc || (r_op == OP_LOCK) || (r_op == OP_RESERVE);
        invert      = !((r_op == OP_LOCK) || (r_op == OP_RESERVE));
        to_reserved = (r_op == OP_RESERVE) || (r_op == OP_UNRESERVE);
    end

    // command setup
    always_comb begin
        c0         = (r_cursor >= r_lim) ? '0 : r_cursor;
        run_n      = (r_op == OP_FREE) ? CNT_W'(1) : r_count;
        run_sum    = IDX_W'(r_first) + IDX_W'(run_n);
        run_short  = run_sum > IDX_W'(r_lim);
        run_end    = run_short ? IDX_W'(r_lim) : run_sum;
        first_out  = CNT_W'(r_first) >= r_lim;
        if (is_alloc) begin
            start_done = (r_lim == '0);
        end else if (is_run) begin
            start_done = (run_n == '0) || first_out;
        end else begin
            start_done = 1'b1;
        end
    end

    // bit window of the word being read
    always_comb begin
        end_w  = r_end[IDX_W-1:BW];
        end_lo = r_end[BW-1:0];
        lo_val = r_first_visit ? {1'b0, r_o0} : '0;
        if (r_final) begin
            hi_val = {1'b0, r_o0};
        end else if (end_w > r_w) begin
            hi_val = (BW+1)'(ROW);
        end else begin
            hi_val = {1'b0, end_lo};
        end
    end

    // word evaluation
    always_comb begin
        fpos = '0;
        for (int j = 0; j < ROW; j++) begin
            mask[j] = ((BW+1)'(j) >= r_lo) && ((BW+1)'(j) < r_hi);
        end
        cand   = (r_rdata ^ {ROW{invert}}) & mask;
        lowest = cand & (~cand + ROW'(1));
        for (int j = 0; j < ROW; j++) begin
            if (lowest[j]) begin
                fpos = fpos | BW'(j);
            end
        end
        chg    = is_alloc ? lowest : (mask & (lowest - ROW'(1)));
        wnew   = set_bits ? (r_rdata | chg) : (r_rdata & ~chg);
        last_w = (end_w == r_w) || ((end_w == WW'(r_w + 1'b1)) && (end_lo == '0));
    end

    // counter update and outcome
    always_comb begin
        cnt_sel = to_reserved ? r_reserved : r_locked;
        cnt_up  = {1'b0, cnt_sel} + (CNT_W+1)'(r_pop);
        if (set_bits) begin
            cnt_new = (cnt_up > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_up[CNT_W-1:0];
        end else begin
            cnt_new = (cnt_sel >= CNT_W'(r_pop)) ? (cnt_sel - CNT_W'(r_pop)) : '0;
        end
        hit_idx  = {r_w, r_fpos};
        nxt_w    = r_last ? '0 : WW'(r_w + 1'b1);
        cnt_done = r_hit || (is_alloc ? r_final : r_last);
    end

    always_comb begin
        used     = {1'b0, r_locked} + {1'b0, r_reserved};
        free_cnt = ({1'b0, r_lim} > used) ? CNT_W'({1'b0, r_lim} - used) : '0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(WORD_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = start_done ? S_OUT : S_RD;
            end
            S_RD:    n_state = S_EVAL;
            S_EVAL:  n_state = S_WR;
            S_WR:    n_state = S_CNT;
            S_CNT: begin
                n_state = cnt_done ? S_OUT : S_RD;
            end
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        busy           = 1'b1;
        o_result_valid = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = AW'(r_w);
        mem_wdata      = r_wdata;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            S_IDLE:  busy = 1'b0;
            S_RD:    mem_re = 1'b1;
            S_WR:    mem_we = 1'b1;
            S_OUT:   o_result_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        o_result.status         = r_status;
        o_result.page_index_out = r_idx_out;
        o_result.page_number    = r_pnum;
        o_result.free_pages     = free_cnt;
        o_result.locked_pages   = r_locked;
        o_result.reserved_pages = r_reserved;
    end

    // bitmap ram, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[AW'(r_w)];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_lim      <= CNT_W'(LIM_RESET);
            r_base     <= '0;
            r_cursor   <= '0;
            r_locked   <= '0;
            r_reserved <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= AW'(r_clr_addr + 1'b1);
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MANAGED: begin
                        r_lim <= (32'(i_cfg_data[CNT_W-1:0]) > MAX_PAGES) ?
                                 CNT_W'(MAX_PAGES) : i_cfg_data[CNT_W-1:0];
                    end
                    CFG_BASE: r_base <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_CNT) begin
                if (to_reserved) begin
                    r_reserved <= cnt_new;
                end else begin
                    r_locked <= cnt_new;
                end
                if (is_alloc && r_hit) begin
                    r_cursor <= CNT_W'(hit_idx);
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op    <= i_cmd.op;
                r_first <= i_cmd.page_index;
                r_count <= i_cmd.page_count;
            end
            S_START: begin
                r_pnum        <= '0;
                r_first_visit <= 1'b1;
                r_final       <= 1'b0;
                if (is_alloc) begin
                    r_status  <= (r_lim == '0) ? ST_FULL : ST_OK;
                    r_idx_out <= '0;
                    r_end     <= IDX_W'(r_lim);
                    r_short   <= 1'b0;
                    r_w       <= WW'(c0 >> BW);
                    r_w0      <= WW'(c0 >> BW);
                    r_o0      <= c0[BW-1:0];
                end else begin
                    r_status  <= (is_run && (run_n != '0) && first_out) ?
                                 ST_RANGE : ST_OK;
                    r_idx_out <= (is_run && (run_n != '0) && first_out) ?
                                 r_first : '0;
                    r_end     <= run_end;
                    r_short   <= run_short;
                    r_w       <= WW'(r_first >> BW);
                    r_w0      <= WW'(r_first >> BW);
                    r_o0      <= r_first[BW-1:0];
                end
            end
            S_RD: begin
                r_lo <= lo_val;
                r_hi <= hi_val;
            end
            S_EVAL: begin
                r_wdata <= wnew;
                r_hit   <= |cand;
                r_fpos  <= fpos;
                r_last  <= last_w;
            end
            S_WR: begin
                if (is_alloc) begin
                    r_pop <= (BW+1)'(r_hit);
                end else begin
                    r_pop <= (r_hit ? {1'b0, r_fpos} : r_hi) - r_lo;
                end
            end
            S_CNT: begin
                r_first_visit <= 1'b0;
                if (is_alloc) begin
                    if (r_hit) begin
                        r_idx_out <= hit_idx[PIDX_W-1:0];
                        r_pnum    <= r_base + PNUM_W'(hit_idx);
                    end else if (r_final) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_w     <= nxt_w;
                        r_final <= (nxt_w == r_w0);
                    end
                end else begin
                    if (r_hit) begin
                        r_status  <= set_bits ? ST_SET : ST_CLEAR;
                        r_idx_out <= hit_idx[PIDX_W-1:0];
                    end else if (r_last) begin
                        if (r_short) begin
                            r_status  <= ST_RANGE;
                            r_idx_out <= r_end[PIDX_W-1:0];
                        end
                    end else begin
                        r_w <= WW'(r_w + 1'b1);
                    end
                end
            end
            default: ;
        endcase
    end

    // checks
    a_result_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_ram_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("ram read and write in the same cycle");

    a_word_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (int'(r_w) < WORD_COUNT))
        else $error("bitmap word beyond the ram");

    a_cmd_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_START))
        else $error("command transfer not taken up");

endmodule

FILE: tb/page_bitmap_allocator_unit_checker.sv
`timescale 1ns / 1ps
// checker for the page bitmap allocator: watches the command, result and config
// channels, keeps its own copy of bitmap, cursor and counts, compares every result
// depends on pba_pkg

module page_bitmap_allocator_unit_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  pba_pkg::t_cmd                 i_cmd,
    input  logic                          i_result_valid,
    input  pba_pkg::t_result              i_result,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [pba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pba_pkg::PNUM_W-1:0]    i_cfg_data,
    output int                            o_mismatches,
    output int                            o_outstanding
);

    import pba_pkg::*;

    localparam int unsigned PAGES = DEF_MAX_PAGES;

    bit                page_used [PAGES];
    logic [PIDX_W-1:0] cursor;
    logic [CNT_W-1:0]  locked_cnt;
    logic [CNT_W-1:0]  reserved_cnt;
    logic [CNT_W-1:0]  managed_cfg;
    logic [PNUM_W-1:0] base_cfg;

    t_result page_results_due [$];
    t_result due;
    t_result fresh;
    int      mismatches = 0;

    function automatic logic [CNT_W-1:0] step_count(logic [CNT_W-1:0] v, bit up);
        if (up)
            return (v == CNT_MAX) ? v : v + 1'b1;
        return (v == '0) ? v : v - 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] seen);
        $display("%0t ns mismatch on %s: expected %0h, got %0h", $time, what, want, seen);
        mismatches++;
    endtask

    task automatic apply_page_op(input t_cmd c, output t_result r);
        int unsigned lim;
        int unsigned cur;
        int unsigned idx;
        int unsigned run_len;
        int unsigned used;
        int unsigned i;
        bit          found;
        bit          set_op;
        bit          on_reserve;
        begin
            lim = (managed_cfg > PAGES) ? PAGES : managed_cfg;
            r   = '0;
            if (c.op == OP_ALLOC) begin
                cur   = (cursor >= lim) ? 0 : cursor;
                found = 1'b0;
                for (i = 0; i < lim; i++) begin
                    if (!page_used[cur]) begin
                        found = 1'b1;
                        break;
                    end
                    cur++;
                    if (cur >= lim)
                        cur = 0;
                end
                if (found) begin
                    page_used[cur]   = 1'b1;
                    locked_cnt       = step_count(locked_cnt, 1'b1);
                    cursor           = cur[PIDX_W-1:0];
                    r.page_index_out = cur[PIDX_W-1:0];
                    r.page_number    = base_cfg + cur;
                end else begin
                    r.status = ST_FULL;
                end
            end else if (c.op <= OP_UNRESERVE) begin
                run_len    = (c.op == OP_FREE) ? 1 : c.page_count;
                set_op     = (c.op == OP_LOCK || c.op == OP_RESERVE);
                on_reserve = (c.op == OP_RESERVE || c.op == OP_UNRESERVE);
                for (i = 0; i < run_len; i++) begin
                    idx = c.page_index + i;
                    if (idx >= lim) begin
                        r.status         = ST_RANGE;
                        r.page_index_out = idx[PIDX_W-1:0];
                        break;
                    end
                    if (page_used[idx] == set_op) begin
                        r.status         = set_op ? ST_SET : ST_CLEAR;
                        r.page_index_out = idx[PIDX_W-1:0];
                        break;
                    end
                    page_used[idx] = set_op;
                    if (on_reserve)
                        reserved_cnt = step_count(reserved_cnt, set_op);
                    else
                        locked_cnt = step_count(locked_cnt, set_op);
                end
            end
            used             = locked_cnt + reserved_cnt;
            r.free_pages     = CNT_W'((lim > used) ? lim - used : 0);
            r.locked_pages   = locked_cnt;
            r.reserved_pages = reserved_cnt;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            page_used    = '{default: 1'b0};
            cursor       = '0;
            locked_cnt   = '0;
            reserved_cnt = '0;
            managed_cfg  = CNT_W'(MANAGED_RESET);
            base_cfg     = '0;
            page_results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MANAGED: managed_cfg = i_cfg_data[CNT_W-1:0];
                    CFG_BASE:    base_cfg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_result_valid) begin
                if (page_results_due.size() == 0) begin
                    flag_mismatch("unexpected result", 64'd0, 64'(i_result.status));
                end else begin
                    due = page_results_due.pop_front();
                    if (i_result.status !== due.status)
                        flag_mismatch("status", 64'(due.status), 64'(i_result.status));
                    if (i_result.page_index_out !== due.page_index_out)
                        flag_mismatch("page_index_out", 64'(due.page_index_out),
                                      64'(i_result.page_index_out));
                    if (i_result.page_number !== due.page_number)
                        flag_mismatch("page_number", 64'(due.page_number),
                                      64'(i_result.page_number));
                    if (i_result.free_pages !== due.free_pages)
                        flag_mismatch("free_pages", 64'(due.free_pages),
                                      64'(i_result.free_pages));
                    if (i_result.locked_pages !== due.locked_pages)
                        flag_mismatch("locked_pages", 64'(due.locked_pages),
                                      64'(i_result.locked_pages));
                    if (i_result.reserved_pages !== due.reserved_pages)
                        flag_mismatch("reserved_pages", 64'(due.reserved_pages),
                                      64'(i_result.reserved_pages));
                end
            end
            if (i_start && !i_busy) begin
                apply_page_op(i_cmd, fresh);
                page_results_due.push_back(fresh);
            end
        end
        o_outstanding <= page_results_due.size();
        o_mismatches  <= mismatches;
    end

endmodule

FILE: tb/page_bitmap_allocator_unit_tb.sv
`timescale 1ns / 1ps
// top of the page bitmap allocator testbench: clock, reset, commands, config
// writes, watchdog and verdict; depends on pba_pkg, the block and its checker

module page_bitmap_allocator_unit_tb;

    import pba_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_ITEMS = 106;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_cmd                 cmd = '0;
    logic                 res_valid;
    t_result              res;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PNUM_W-1:0]    cfg_data = '0;
    int                   mismatches;
    int                   outstanding;
    int                   idle_pct = 0;

    page_bitmap_allocator_unit u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (cmd),
        .o_result_valid (res_valid),
        .o_result       (res),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    page_bitmap_allocator_unit_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cmd          (cmd),
        .i_result_valid (res_valid),
        .i_result       (res),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // any transfer on any channel restarts the count
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((start && !busy) || res_valid || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic issue(input logic [OP_W-1:0] op, input logic [PIDX_W-1:0] idx,
                         input logic [CNT_W-1:0] cnt);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= '{op: op, page_index: idx, page_count: cnt};
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    task automatic quiesce();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [PNUM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [PNUM_W-1:0] managed_data,
                            input logic [PNUM_W-1:0] base_data);
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_MANAGED, managed_data);
            write_reg(CFG_BASE, base_data);
        end else begin
            write_reg(CFG_BASE, base_data);
            write_reg(CFG_MANAGED, managed_data);
        end
    endtask

    initial begin : stimulus
        logic [PNUM_W-1:0] mdata;
        logic [PNUM_W-1:0] bdata;
        logic [OP_W-1:0]   op;
        logic [PIDX_W-1:0] idx;
        logic [CNT_W-1:0]  cnt;
        int unsigned       lim;
        int unsigned       pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at reset configuration
        issue(OP_ALLOC, 16'd0, 17'd1);
        issue(OP_ALLOC, 16'd0, 17'd1);
        issue(OP_FREE, 16'd0, 17'd1);
        issue(OP_FREE, 16'd0, 17'd1);
        issue(OP_LOCK, 16'd10, 17'd5);
        issue(OP_LOCK, 16'd12, 17'd3);
        issue(OP_UNLOCK, 16'd10, 17'd6);
        issue(OP_RESERVE, 16'd100, 17'd0);
        issue(OP_RESERVE, 16'hFFFE, 17'd4);
        issue(OP_UNRESERVE, 16'hFFFF, 17'd1);
        issue(OP_UNLOCK, 16'hFFFE, 17'd1);
        issue(3'd6, 16'hFFFF, 17'h1FFFF);
        issue(3'd7, 16'd0, 17'd0);
        issue(OP_FREE, 16'hFFFF, 17'd1);
        issue(OP_FREE, 16'd1, 17'd1);
        issue(OP_LOCK, 16'd0, 17'h10000);
        issue(OP_ALLOC, 16'd0, 17'd0);
        issue(OP_RESERVE, 16'h8000, 17'd1);
        issue(OP_UNLOCK, 16'd0, 17'h10000);

        // no pages under management
        quiesce();
        set_regs(52'd0, 52'd0);
        issue(OP_ALLOC, 16'd0, 17'd1);
        issue(OP_FREE, 16'd0, 17'd1);

        // bound capped, base at the top so the page number wraps
        quiesce();
        set_regs({35'h7_FFFF_FFFF, 17'h1FFFF}, 52'hF_FFFF_FFFF_FFFF);
        issue(OP_ALLOC, 16'd0, 17'd1);
        issue(OP_ALLOC, 16'd0, 17'd1);

        // single page
        quiesce();
        set_regs(52'd1, 52'd5);
        issue(OP_ALLOC, 16'd0, 17'd1);
        issue(OP_ALLOC, 16'd0, 17'd1);
        issue(OP_RESERVE, 16'd0, 17'd1);
        issue(OP_FREE, 16'd0, 17'd1);

        for (int ph = 0; ph < 8; ph++) begin
            quiesce();
            case (ph)
                0: mdata = 52'd64;
                1: mdata = PNUM_W'($urandom_range(65, 300));
                2: mdata = 52'd65536;
                3: mdata = PNUM_W'($urandom_range(1, 4));
                4: mdata = PNUM_W'($urandom_range(1, 200));
                5: begin
                    mdata = PNUM_W'({$urandom, $urandom});
                    mdata[CNT_W-1:0] = 17'h1FFFF;
                end
                6: mdata = 52'd1;
                default: mdata = PNUM_W'($urandom_range(100, 700));
            endcase
            case ($urandom_range(0, 3))
                0: bdata = '0;
                1: bdata = '1;
                default: bdata = PNUM_W'({$urandom, $urandom});
            endcase
            set_regs(mdata, bdata);
            lim = (mdata[CNT_W-1:0] > DEF_MAX_PAGES) ? DEF_MAX_PAGES : mdata[CNT_W-1:0];
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 47;
                default: idle_pct = 7;
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 30)      op = OP_ALLOC;
                else if (pick < 42) op = OP_FREE;
                else if (pick < 55) op = OP_LOCK;
                else if (pick < 68) op = OP_UNLOCK;
                else if (pick < 81) op = OP_RESERVE;
                else if (pick < 94) op = OP_UNRESERVE;
                else                op = OP_W'($urandom_range(6, 7));

                pick = $urandom_range(0, 99);
                if (pick < 85)      idx = PIDX_W'($urandom_range(0, lim - 1));
                else if (pick < 93) idx = PIDX_W'(lim - 1 + $urandom_range(0, 3));
                else                idx = PIDX_W'($urandom);

                pick = $urandom_range(0, 99);
                if (pick < 70)      cnt = CNT_W'($urandom_range(1, 4));
                else if (pick < 90) cnt = CNT_W'($urandom_range(1, 16));
                else if (pick < 97) cnt = CNT_W'($urandom_range(0, lim + 3));
                else if (pick < 99) cnt = 17'h10000;
                else                cnt = CNT_W'($urandom);

                issue(op, idx, cnt);
            end
        end

        quiesce();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
